### hw/rtl/pgcb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pgcb_pkg;

  // Curve store geometry
  localparam int CURVE_DEPTH = 256;
  localparam int CURVE_AW    = 8;
  localparam int CURVE_DW    = 16;

  // Q1.15 half, subtracted before the contrast gain and added back after
  localparam logic signed [16:0] HALF_Q15_D = 17'sd16384;
  localparam logic signed [20:0] HALF_Q15_C = 21'sd16384;

  // Channel ceiling
  localparam logic [17:0] CH_MAX = 18'd255;

  // Configuration port
  localparam int ADDR_W = 3;
  localparam logic REG_CONTRAST   = 1'b0;
  localparam logic REG_BRIGHTNESS = 1'b1;
  localparam logic [15:0] GAIN_UNITY = 16'd4096;

  // Input word modes
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_CURVE = 1'b1;

  // Per-stage load strobes shared by all lanes
  typedef struct packed {
    logic wr;   // curve entry write
    logic ld1;  // curve read into stage 1
    logic ld2;  // contrast product into stage 2
    logic ld3;  // brightness product into stage 3
  } lane_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/pgcb_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module pgcb_lane (
  input  wire logic                      clk,
  input  wire pgcb_pkg::lane_ctl_t       ctl,
  input  wire logic [pgcb_pkg::CURVE_AW-1:0] wr_addr,
  input  wire logic [pgcb_pkg::CURVE_DW-1:0] wr_data,
  input  wire logic [pgcb_pkg::CURVE_AW-1:0] rd_addr,
  input  wire logic [15:0]               contrast,
  input  wire logic [15:0]               brightness,
  output      logic [7:0]                pix
);

  logic [pgcb_pkg::CURVE_DW-1:0] curve_mem [pgcb_pkg::CURVE_DEPTH];
  logic [15:0]        g_r;
  logic signed [32:0] p1_r;
  logic signed [37:0] p2_r;

  logic signed [16:0] diff;
  logic signed [33:0] prod1;
  logic signed [20:0] c_val;
  logic signed [37:0] prod2;
  logic signed [25:0] b_val;
  logic [32:0]        scaled;
  logic [17:0]        v_val;

  // Curve store, one private copy per lane; registered read
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      curve_mem[wr_addr] <= wr_data;
    end
    if (ctl.ld1) begin
      g_r <= curve_mem[rd_addr];
    end
  end

  // Contrast: (g - half) * gain
  always_comb begin
    diff  = $signed({1'b0, g_r}) - pgcb_pkg::HALF_Q15_D;
    prod1 = diff * $signed({1'b0, contrast});
  end

  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      p1_r <= prod1[32:0];
    end
  end

  // Floor shift, re-center, brightness product
  always_comb begin
    c_val = $signed(p1_r[32:12]) + pgcb_pkg::HALF_Q15_C;
    prod2 = c_val * $signed({1'b0, brightness});
  end

  always_ff @(posedge clk) begin
    if (ctl.ld3) begin
      p2_r <= prod2;
    end
  end

  // Scale by 255/32768 and clamp; b fits 25 bits when positive
  always_comb begin
    b_val  = p2_r[37:12];
    scaled = {b_val[24:0], 8'b0} - {8'b0, b_val[24:0]};
    v_val  = scaled[32:15];
    if (b_val <= 26'sd0) begin
      pix = 8'd0;
    end else if (v_val > pgcb_pkg::CH_MAX) begin
      pix = 8'hFF;
    end else begin
      pix = v_val[7:0];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/pixel_gamma_contrast_brightness.sv
// Pixel path: curve read, contrast and brightness stages, output register, out_*.
// Throughput: one word per cycle, pixel or curve write, while in_ready is
// high; a curve write gives no output word. Three lanes, each with own curve.
// Reset (rst_n low, synchronous): pipeline and output emptied, both gains
// set to unity (4096); the gamma curve is not cleared and must be loaded.
`timescale 1ns / 1ps
`default_nettype none

module pixel_gamma_contrast_brightness (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input channel
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic                        in_mode,
  input  wire logic [7:0]                  in_red_in,
  input  wire logic [7:0]                  in_green_in,
  input  wire logic [7:0]                  in_blue_in,
  input  wire logic [7:0]                  in_curve_index,
  input  wire logic [15:0]                 in_curve_value,
  // result channel
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic [7:0]                  out_red_out,
  output      logic [7:0]                  out_green_out,
  output      logic [7:0]                  out_blue_out,
  // configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pgcb_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output      logic [31:0]                 prdata,
  output      logic                        pready
);

  logic [15:0] contrast_r;
  logic [15:0] brightness_r;
  logic        v1_r, v2_r, v3_r, out_valid_r;
  logic        v1_nxt, v2_nxt, v3_nxt, out_valid_nxt;
  logic [7:0]  red_r, green_r, blue_r;

  logic        mv_out, ld4, free3, free2, free1, acc;
  logic        cfg_wr;
  pgcb_pkg::lane_ctl_t ctl;
  logic [7:0]  red_pix, green_pix, blue_pix;

  // Config registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      contrast_r   <= pgcb_pkg::GAIN_UNITY;
      brightness_r <= pgcb_pkg::GAIN_UNITY;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        pgcb_pkg::REG_CONTRAST:   contrast_r   <= pwdata[15:0];
        pgcb_pkg::REG_BRIGHTNESS: brightness_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      pgcb_pkg::REG_CONTRAST:   prdata = {16'b0, contrast_r};
      pgcb_pkg::REG_BRIGHTNESS: prdata = {16'b0, brightness_r};
      default:                  prdata = 32'b0;
    endcase
  end

  // Stage advance: a stage loads when the one after it is empty or moving
  always_comb begin
    mv_out   = !out_valid_r || out_ready;
    ld4      = v3_r && mv_out;
    free3    = !v3_r || ld4;
    ctl.ld3  = v2_r && free3;
    free2    = !v2_r || ctl.ld3;
    ctl.ld2  = v1_r && free2;
    free1    = !v1_r || ctl.ld2;
    in_ready = free1;
    acc      = in_valid && free1;
    ctl.ld1  = acc && (in_mode == pgcb_pkg::MODE_PIXEL);
    ctl.wr   = acc && (in_mode == pgcb_pkg::MODE_CURVE);
  end

  always_comb begin
    v1_nxt        = ctl.ld1 || (v1_r && !ctl.ld2);
    v2_nxt        = ctl.ld2 || (v2_r && !ctl.ld3);
    v3_nxt        = ctl.ld3 || (v3_r && !ld4);
    out_valid_nxt = ld4 || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      v3_r        <= v3_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Channel lanes
  pgcb_lane u_lane_red (
    .clk        (clk),
    .ctl        (ctl),
    .wr_addr    (in_curve_index),
    .wr_data    (in_curve_value),
    .rd_addr    (in_red_in),
    .contrast   (contrast_r),
    .brightness (brightness_r),
    .pix        (red_pix)
  );

  pgcb_lane u_lane_green (
    .clk        (clk),
    .ctl        (ctl),
    .wr_addr    (in_curve_index),
    .wr_data    (in_curve_value),
    .rd_addr    (in_green_in),
    .contrast   (contrast_r),
    .brightness (brightness_r),
    .pix        (green_pix)
  );

  pgcb_lane u_lane_blue (
    .clk        (clk),
    .ctl        (ctl),
    .wr_addr    (in_curve_index),
    .wr_data    (in_curve_value),
    .rd_addr    (in_blue_in),
    .contrast   (contrast_r),
    .brightness (brightness_r),
    .pix        (blue_pix)
  );

  // Merge lanes into the output word register
  always_ff @(posedge clk) begin
    if (ld4) begin
      red_r   <= red_pix;
      green_r <= green_pix;
      blue_r  <= blue_pix;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = red_r;
  assign out_green_out = green_r;
  assign out_blue_out  = blue_r;

  // Checks
  a_pixel_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_mode == pgcb_pkg::MODE_PIXEL) |=> v1_r)
    else $error("accepted pixel word did not enter stage 1");

  a_curve_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_mode == pgcb_pkg::MODE_CURVE) |=>
      (v1_r == $past(v1_r && !ctl.ld2)))
    else $error("curve write produced a pipeline word");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input taken while pipeline full and stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && !$past(ld4)))
    else $error("output word overwritten while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> (!out_valid_r && !v1_r))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
